>>> design/keyframe_linear_interpolator_macros.svh
// ----------------------------------------------------------------------------
// Keyframe interpolator assertion macros
// Shared concurrent assertion forms for the interpolator checkers.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define KLI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/kli_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe interpolator package
// Types, request codes and constants shared across the interpolator.
// ----------------------------------------------------------------------------
package kli_pkg;

    localparam int KEY_DEPTH = 16;
    localparam int ADDR_W    = $clog2(KEY_DEPTH);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int QUOT_W    = 16;
    localparam int RATIO_W   = 17;
    localparam int LANE_W    = 18;

    localparam logic [CNT_W-1:0]   KEY_DEPTH_C = CNT_W'(KEY_DEPTH);
    localparam logic [RATIO_W-1:0] ONE_Q16     = 17'h10000;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_RSVD   = 2'd3
    } t_req;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        key_time;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [15:0]        zoom_in;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic [15:0]        out_zoom;
        logic [16:0]        out_ratio;
        logic               past_end;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic [31:0]        key_time;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [15:0]        zoom;
    } t_key;

    // start of a serial unit
    typedef struct packed {
        logic start;
    } t_unit_ctl;

endpackage

>>> design/kli_in_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one request beat.
// ----------------------------------------------------------------------------
interface kli_in_if;
    import kli_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/kli_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface kli_out_if;
    import kli_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/keyframe_linear_interpolator.sv
// ----------------------------------------------------------------------------
// Keyframe linear interpolator
// Keyframe table with serial search, serial ratio divide and serial blend.
//
//   channel   dir  handshake          beat
//   i_in      in   valid/ready        request (append, sample, clear)
//   o_out     out  valid/ready        one result per request
//   i_cfg_*   in   write enable       fade_mode
//
// Append, clear and the unused code finish at acceptance and pass through S_DONE.
// A sample loads the first entry (S_LD0), scans N entries, one per cycle from the RAM
// read port (S_SCAN), then runs the ratio divider and the blend lanes; a clamped ratio
// skips the divider, fade mode skips the blend, and past the end skips both.
// One request is in flight; while a result waits on o_out, the next result holds the block in S_DONE.
// Reset is synchronous, active low, and empties the table.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kli_in_if.sink      i_in,
    kli_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);
    import kli_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LD0, S_SCAN, S_RAT, S_DIV, S_BLEND, S_MUL, S_DONE
    } t_state;

    t_state             r_state;
    logic               r_fade;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_idx;
    logic [31:0]        r_t;
    t_key               r_prev;
    t_key               r_next;
    t_key               r_rdata;
    logic [RATIO_W-1:0] r_ratio;
    t_out_item          r_res;
    t_out_item          r_out;
    logic               r_ovalid;
    t_key               mem [KEY_DEPTH];

    logic [ADDR_W-1:0]  w_raddr;
    logic               w_acc;
    logic               w_wr;
    t_key               w_wkey;
    logic [1:0]         w_status;
    t_unit_ctl          w_div_ctl;
    t_unit_ctl          w_mac_ctl;
    logic               w_div_done;
    logic [QUOT_W-1:0]  w_quot;
    logic               w_mac_done;
    logic [3:0]         w_mac_dn;
    logic [15:0]        w_mx, w_my, w_mz, w_mzoom;
    logic signed [32:0] w_num, w_den;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_acc       = i_in.valid && i_in.ready;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    assign w_wr = w_acc && (t_req'(i_in.data.req_type) == REQ_APPEND)
                  && (r_count < KEY_DEPTH_C);
    assign w_wkey = '{key_time: i_in.data.key_time, x: i_in.data.pos_x,
                      y: i_in.data.pos_y, z: i_in.data.pos_z,
                      zoom: i_in.data.zoom_in};

    // status of a request that finishes right at acceptance
    always_comb begin
        priority if ((t_req'(i_in.data.req_type) == REQ_APPEND)
                     && (r_count >= KEY_DEPTH_C)) begin
            w_status = STAT_FULL;
        end else if ((t_req'(i_in.data.req_type) == REQ_SAMPLE)
                     && (r_count == '0)) begin
            w_status = STAT_EMPTY;
        end else begin
            w_status = STAT_OK;
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:  w_raddr = '0;
            S_LD0:   w_raddr = ADDR_W'(1);
            default: w_raddr = r_idx[ADDR_W-1:0] + 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem[r_count[ADDR_W-1:0]] <= w_wkey;
        end
        r_rdata <= mem[w_raddr];
    end

    assign w_num = {1'b0, r_t} - {1'b0, r_prev.key_time};
    assign w_den = {1'b0, r_next.key_time} - {1'b0, r_prev.key_time};

    assign w_div_ctl.start = (r_state == S_RAT) && (w_den > 0) && (w_num > 0)
                             && (w_num < w_den);
    assign w_mac_ctl.start = (r_state == S_BLEND) && !r_fade;

    kli_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_div_ctl),
        .i_num(w_num[31:0]), .i_den(w_den[31:0]),
        .o_done(w_div_done), .o_quot(w_quot)
    );

    kli_mac u_mac_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_mac_ctl), .i_ratio(r_ratio),
        .i_before(LANE_W'(r_prev.x)), .i_after(LANE_W'(r_next.x)),
        .o_done(w_mac_dn[0]), .o_result(w_mx)
    );
    kli_mac u_mac_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_mac_ctl), .i_ratio(r_ratio),
        .i_before(LANE_W'(r_prev.y)), .i_after(LANE_W'(r_next.y)),
        .o_done(w_mac_dn[1]), .o_result(w_my)
    );
    kli_mac u_mac_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_mac_ctl), .i_ratio(r_ratio),
        .i_before(LANE_W'(r_prev.z)), .i_after(LANE_W'(r_next.z)),
        .o_done(w_mac_dn[2]), .o_result(w_mz)
    );
    kli_mac u_mac_zoom (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_mac_ctl), .i_ratio(r_ratio),
        .i_before(signed'({2'b00, r_prev.zoom})),
        .i_after(signed'({2'b00, r_next.zoom})),
        .o_done(w_mac_dn[3]), .o_result(w_mzoom)
    );

    assign w_mac_done = &w_mac_dn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fade   <= 1'b0;
            r_count  <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fade <= i_cfg_wdata;
            end
            if (r_ovalid && o_out.ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_t   <= i_in.data.key_time;
                        r_res <= t_out_item'({{($bits(t_out_item) - 2){1'b0}}, w_status});
                        r_state <= S_DONE;
                        unique case (t_req'(i_in.data.req_type))
                            REQ_APPEND: begin
                                if (r_count < KEY_DEPTH_C) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            REQ_SAMPLE: begin
                                if (r_count != '0) begin
                                    r_state <= S_LD0;
                                end
                            end
                            REQ_CLEAR: r_count <= '0;
                            REQ_RSVD:  ;
                        endcase
                    end
                end
                S_LD0: begin
                    r_prev  <= r_rdata;
                    r_idx   <= CNT_W'(1);
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    priority if (r_idx >= r_count) begin
                        // past the last keyframe: return it as is
                        r_res.out_x     <= r_prev.x;
                        r_res.out_y     <= r_prev.y;
                        r_res.out_z     <= r_prev.z;
                        r_res.out_zoom  <= r_prev.zoom;
                        r_res.out_ratio <= ONE_Q16;
                        r_res.past_end  <= 1'b1;
                        r_state         <= S_DONE;
                    end else if (r_rdata.key_time < r_t) begin
                        r_prev <= r_rdata;
                        r_idx  <= r_idx + 1'b1;
                    end else begin
                        r_next  <= r_rdata;
                        r_state <= S_RAT;
                    end
                end
                S_RAT: begin
                    priority if (w_den == 0) begin
                        r_ratio <= '0;
                        r_state <= S_BLEND;
                    end else if (w_den < 0) begin
                        r_ratio <= ONE_Q16;
                        r_state <= S_BLEND;
                    end else if (w_num <= 0) begin
                        r_ratio <= '0;
                        r_state <= S_BLEND;
                    end else if (w_num >= w_den) begin
                        r_ratio <= ONE_Q16;
                        r_state <= S_BLEND;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_ratio <= {1'b0, w_quot};
                        r_state <= S_BLEND;
                    end
                end
                S_BLEND: begin
                    r_res.out_ratio <= r_ratio;
                    if (r_fade) begin
                        r_res.out_zoom <= {3'b000, r_ratio[RATIO_W-1:4]};
                        r_state        <= S_DONE;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (w_mac_done) begin
                        r_res.out_x    <= w_mx;
                        r_res.out_y    <= w_my;
                        r_res.out_z    <= w_mz;
                        r_res.out_zoom <= w_mzoom;
                        r_state        <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the result register frees
                    if (!r_ovalid || o_out.ready) begin
                        r_out    <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> design/kli_div.sv
// ----------------------------------------------------------------------------
// Serial ratio divider
// Restoring divider, one quotient bit per cycle: (num << 16) / den, num < den.
// ----------------------------------------------------------------------------
module kli_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  kli_pkg::t_unit_ctl        i_ctl,
    input  logic [31:0]               i_num,
    input  logic [31:0]               i_den,
    output logic                      o_done,
    output logic [kli_pkg::QUOT_W-1:0] o_quot
);
    import kli_pkg::*;

    localparam int CW = $clog2(QUOT_W + 1);

    logic [32:0]       r_rem;
    logic [31:0]       r_den;
    logic [QUOT_W-1:0] r_quot;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [32:0]       w_rem2;
    logic              w_ge;

    assign w_rem2 = {r_rem[31:0], 1'b0};
    assign w_ge   = w_rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QUOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? (w_rem2 - {1'b0, r_den}) : w_rem2;
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

>>> design/kli_mac.sv
// ----------------------------------------------------------------------------
// Serial blend lane
// Shift-add multiply, one ratio bit per cycle: prev*65536 + r*(next-prev),
// then divide by 65536 truncating toward zero.
// ----------------------------------------------------------------------------
module kli_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  kli_pkg::t_unit_ctl                 i_ctl,
    input  logic [kli_pkg::RATIO_W-1:0]        i_ratio,
    input  logic signed [kli_pkg::LANE_W-1:0]  i_before,
    input  logic signed [kli_pkg::LANE_W-1:0]  i_after,
    output logic                               o_done,
    output logic [15:0]                        o_result
);
    import kli_pkg::*;

    localparam int AW = 36;
    localparam int CW = $clog2(RATIO_W + 1);

    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] r_dsh;
    logic [RATIO_W-1:0]   r_rsh;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic signed [AW-1:0] w_bias;
    logic signed [LANE_W-1:0] w_diff;

    assign w_diff = i_after - i_before;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(RATIO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_acc <= AW'(i_before) <<< 16;
            r_dsh <= AW'(w_diff);
            r_rsh <= i_ratio;
        end else if (r_busy) begin
            if (r_rsh[0]) begin
                r_acc <= r_acc + r_dsh;
            end
            r_dsh <= r_dsh <<< 1;
            r_rsh <= r_rsh >> 1;
        end
    end

    // round toward zero on negative sums
    assign w_bias   = r_acc[AW-1] ? (r_acc + AW'(65535)) : r_acc;
    assign o_result = w_bias[31:16];
    assign o_done   = r_done;
endmodule

>>> design/kli_checker.sv
// ----------------------------------------------------------------------------
// Interpolator port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "keyframe_linear_interpolator_macros.svh"

module kli_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [16:0] i_out_ratio,
    input logic        i_out_past,
    input logic [1:0]  i_out_status
);
    import kli_pkg::*;

    `KLI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result beat dropped while stalled")
    `KLI_ASSERT_NEXT(a_one_inflight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "request taken while busy")
    `KLI_ASSERT_NOW(a_status_code, i_clk, i_rst_n, i_out_valid, i_out_status != 2'd3, "bad status code")
    `KLI_ASSERT_NOW(a_past_end, i_clk, i_rst_n, i_out_valid && i_out_past, (i_out_ratio == ONE_Q16) && (i_out_status == STAT_OK), "past end result inconsistent")
    `KLI_ASSERT_NOW(a_ratio_max, i_clk, i_rst_n, i_out_valid, i_out_ratio <= ONE_Q16, "ratio above one")
endmodule

bind keyframe_linear_interpolator kli_checker u_kli_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_ratio  (o_out.data.out_ratio),
    .i_out_past   (o_out.data.past_end),
    .i_out_status (o_out.data.status)
);
